FILE: hw/rtl/sha_pkg.sv
// Shared types and codes for the segment hole allocator.
// No dependencies; used by the cell, the top level and the checker.
package sha_pkg;

  localparam logic [1:0] CMD_INIT     = 2'd0;
  localparam logic [1:0] CMD_ALLOCATE = 2'd1;
  localparam logic [1:0] CMD_FREE     = 2'd2;
  localparam logic [1:0] CMD_COMPACT  = 2'd3;

  localparam logic [2:0] ST_ALLOCATED   = 3'd0;
  localparam logic [2:0] ST_COMPACT_REQ = 3'd1;
  localparam logic [2:0] ST_NO_MEMORY   = 3'd2;
  localparam logic [2:0] ST_FREED       = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd4;
  localparam logic [2:0] ST_COMPACTED   = 3'd5;
  localparam logic [2:0] ST_INITIALIZED = 3'd6;

  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam logic [1:0] CFG_FIT_MODE      = 2'd0;
  localparam logic [1:0] CFG_MEMORY_SIZE   = 2'd1;
  localparam logic [1:0] CFG_RESERVED_SIZE = 2'd2;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LD_START,
    CELL_LD_END,
    CELL_LD_BOTH,
    CELL_FROM_PREV,
    CELL_FROM_NEXT
  } sha_cell_op_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] request_size;
    logic [31:0] region_base;
    logic [31:0] region_limit;
  } sha_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_base;
    logic [4:0]  hole_count;
  } sha_res_t;

endpackage

FILE: hw/rtl/sha_cell.sv
// One hole entry of the table: holds start and end, loads or takes a neighbor.
// Depends on sha_pkg.
module sha_cell #(
  parameter int AW = 32
) (
  input  logic                  clk_i,
  input  sha_pkg::sha_cell_op_e op_i,
  input  logic [AW-1:0]         ld_start_i,
  input  logic [AW-1:0]         ld_end_i,
  input  logic [AW-1:0]         prev_start_i,
  input  logic [AW-1:0]         prev_end_i,
  input  logic [AW-1:0]         next_start_i,
  input  logic [AW-1:0]         next_end_i,
  output logic [AW-1:0]         start_o,
  output logic [AW-1:0]         end_o
);

  logic [AW-1:0] start_q, start_d;
  logic [AW-1:0] end_q, end_d;

  always_comb begin
    start_d = start_q;
    end_d   = end_q;
    unique case (op_i)
      sha_pkg::CELL_HOLD: begin
      end
      sha_pkg::CELL_LD_START: begin
        start_d = ld_start_i;
      end
      sha_pkg::CELL_LD_END: begin
        end_d = ld_end_i;
      end
      sha_pkg::CELL_LD_BOTH: begin
        start_d = ld_start_i;
        end_d   = ld_end_i;
      end
      sha_pkg::CELL_FROM_PREV: begin
        start_d = prev_start_i;
        end_d   = prev_end_i;
      end
      sha_pkg::CELL_FROM_NEXT: begin
        start_d = next_start_i;
        end_d   = next_end_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
  end

  assign start_o = start_q;
  assign end_o   = end_q;

endmodule

FILE: hw/rtl/segment_hole_allocator.sv
// One command at a time; the next one is taken in the cycle its result shows.
// The sequencer steps one table entry per cycle.
// The result shows for one cycle on res_valid_o; the receiver cannot stall.
// Reset empties the table and loads the register defaults.
// Top level of the segment hole allocator; depends on sha_pkg and sha_cell.
module segment_hole_allocator #(
  parameter int MAX_HOLES = 16,
  parameter int ADDR_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sha_pkg::sha_req_t req_i,
  output logic              res_valid_o,
  output sha_pkg::sha_res_t res_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i
);

  localparam int AW = ADDR_BITS;
  localparam int IW = $clog2(MAX_HOLES);
  localparam int CW = $clog2(MAX_HOLES + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_ADONE = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;
  localparam logic [2:0] S_FDONE = 3'd4;
  localparam logic [2:0] S_INS   = 3'd5;
  localparam logic [2:0] S_COMP  = 3'd6;

  localparam logic [1:0] LD_NONE  = 2'd0;
  localparam logic [1:0] LD_START = 2'd1;
  localparam logic [1:0] LD_END   = 2'd2;
  localparam logic [1:0] LD_BOTH  = 2'd3;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] k_q, k_d, cnt_q, cnt_d;
  logic          found_q, found_d;
  logic [IW-1:0] pick_q, pick_d, up_q, up_d;
  logic [AW-1:0] psize_q, psize_d, pstart_q, pstart_d, pend_q, pend_d;
  logic [AW-1:0] sum_q, sum_d;
  logic [AW-1:0] rq_q, rq_d, rb_q, rb_d, rl_q, rl_d;
  logic [1:0]    fit_q;
  logic [AW-1:0] mem_q, rsv_q;
  logic          rv_q, rv_d;
  sha_pkg::sha_res_t res_q, res_d;

  logic [AW-1:0] cell_start [MAX_HOLES];
  logic [AW-1:0] cell_end   [MAX_HOLES];
  sha_pkg::sha_cell_op_e cell_op [MAX_HOLES];

  logic [AW-1:0] rd_start, rd_end, rd_size, ld_start, ld_end, sat_sum, alloc_lim;
  logic [AW:0]   sum_wide;
  logic          in_range;
  logic          ld_en, sd_en, su_en;
  logic [1:0]    ld_kind;
  logic [CW-1:0] ld_idx, sd_idx, su_idx;

  assign rd_start  = cell_start[k_q[IW-1:0]];
  assign rd_end    = cell_end[k_q[IW-1:0]];
  assign rd_size   = (rd_end > rd_start) ? rd_end - rd_start : '0;
  assign sum_wide  = {1'b0, sum_q} + {1'b0, rd_size};
  assign sat_sum   = sum_wide[AW] ? '1 : sum_wide[AW-1:0];
  assign in_range  = k_q < cnt_q;
  assign alloc_lim = pstart_q + rq_q;
  assign busy      = state_q != S_IDLE;

  always_comb begin
    state_d  = state_q;
    k_d      = k_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    pick_d   = pick_q;
    up_d     = up_q;
    psize_d  = psize_q;
    pstart_d = pstart_q;
    pend_d   = pend_q;
    sum_d    = sum_q;
    rq_d     = rq_q;
    rb_d     = rb_q;
    rl_d     = rl_q;
    rv_d     = 1'b0;
    res_d    = res_q;
    ld_en    = 1'b0;
    ld_kind  = LD_NONE;
    ld_idx   = '0;
    ld_start = '0;
    ld_end   = '0;
    sd_en    = 1'b0;
    sd_idx   = '0;
    su_en    = 1'b0;
    su_idx   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          rq_d    = AW'(req_i.request_size);
          rb_d    = AW'(req_i.region_base);
          rl_d    = AW'(req_i.region_limit);
          k_d     = '0;
          found_d = 1'b0;
          sum_d   = '0;
          unique case (req_i.cmd)
            sha_pkg::CMD_INIT: begin
              ld_en    = 1'b1;
              ld_kind  = LD_BOTH;
              ld_start = rsv_q;
              ld_end   = mem_q;
              cnt_d    = CW'(1);
              rv_d     = 1'b1;
              res_d.status      = sha_pkg::ST_INITIALIZED;
              res_d.result_base = 32'(rsv_q);
              res_d.hole_count  = 5'd1;
            end
            sha_pkg::CMD_ALLOCATE: state_d = S_ALLOC;
            sha_pkg::CMD_FREE:     state_d = S_FREE;
            default:               state_d = S_COMP;
          endcase
        end
      end
      S_ALLOC: begin
        if (in_range) begin
          sum_d = sat_sum;
          k_d   = k_q + CW'(1);
          if (rq_q <= rd_size) begin
            if (!found_q) begin
              found_d  = 1'b1;
              pick_d   = k_q[IW-1:0];
              psize_d  = rd_size;
              pstart_d = rd_start;
              pend_d   = rd_end;
              if (fit_q != sha_pkg::FIT_BEST && fit_q != sha_pkg::FIT_WORST) begin
                state_d = S_ADONE;
              end
            end else if ((fit_q == sha_pkg::FIT_BEST && rd_size < psize_q) ||
                         (fit_q == sha_pkg::FIT_WORST && rd_size > psize_q)) begin
              pick_d   = k_q[IW-1:0];
              psize_d  = rd_size;
              pstart_d = rd_start;
              pend_d   = rd_end;
            end
          end
        end else begin
          state_d = S_ADONE;
        end
      end
      S_ADONE: begin
        state_d = S_IDLE;
        rv_d    = 1'b1;
        res_d.result_base = '0;
        if (found_q) begin
          res_d.status      = sha_pkg::ST_ALLOCATED;
          res_d.result_base = 32'(pstart_q);
          if (alloc_lim == pend_q) begin
            sd_en  = 1'b1;
            sd_idx = CW'(pick_q);
            cnt_d  = cnt_q - CW'(1);
          end else begin
            ld_en    = 1'b1;
            ld_kind  = LD_START;
            ld_idx   = CW'(pick_q);
            ld_start = alloc_lim;
          end
        end else begin
          res_d.status = (sum_q >= rq_q) ? sha_pkg::ST_COMPACT_REQ : sha_pkg::ST_NO_MEMORY;
        end
        res_d.hole_count = 5'(cnt_d);
      end
      S_FREE: begin
        if (!in_range || rl_q < rd_start) begin
          state_d = S_FDONE;
        end else if (rl_q == rd_start) begin
          state_d = S_FDONE;
          if (found_q) begin
            ld_en   = 1'b1;
            ld_kind = LD_END;
            ld_idx  = CW'(up_q);
            ld_end  = rd_end;
            sd_en   = 1'b1;
            sd_idx  = k_q;
            cnt_d   = cnt_q - CW'(1);
          end else begin
            ld_en    = 1'b1;
            ld_kind  = LD_START;
            ld_idx   = k_q;
            ld_start = rb_q;
            found_d  = 1'b1;
          end
        end else begin
          k_d = k_q + CW'(1);
          if (rb_q == rd_end) begin
            up_d    = k_q[IW-1:0];
            ld_en   = 1'b1;
            ld_kind = LD_END;
            ld_idx  = k_q;
            ld_end  = rl_q;
            found_d = 1'b1;
          end
        end
      end
      S_FDONE: begin
        res_d.result_base = '0;
        res_d.hole_count  = 5'(cnt_q);
        if (found_q) begin
          state_d      = S_IDLE;
          rv_d         = 1'b1;
          res_d.status = sha_pkg::ST_FREED;
        end else if (cnt_q >= CW'(MAX_HOLES)) begin
          state_d      = S_IDLE;
          rv_d         = 1'b1;
          res_d.status = sha_pkg::ST_TABLE_FULL;
        end else begin
          state_d = S_INS;
          k_d     = '0;
        end
      end
      S_INS: begin
        if (in_range && !(rb_q < rd_start)) begin
          k_d = k_q + CW'(1);
        end else begin
          su_en    = 1'b1;
          su_idx   = k_q;
          ld_en    = 1'b1;
          ld_kind  = LD_BOTH;
          ld_idx   = k_q;
          ld_start = rb_q;
          ld_end   = rl_q;
          cnt_d    = cnt_q + CW'(1);
          state_d  = S_IDLE;
          rv_d     = 1'b1;
          res_d.status      = sha_pkg::ST_FREED;
          res_d.result_base = '0;
          res_d.hole_count  = 5'(cnt_d);
        end
      end
      S_COMP: begin
        if (in_range) begin
          sum_d = sat_sum;
          k_d   = k_q + CW'(1);
        end else begin
          ld_en    = 1'b1;
          ld_kind  = LD_BOTH;
          ld_start = (sum_q >= mem_q) ? '0 : mem_q - sum_q;
          ld_end   = mem_q;
          cnt_d    = CW'(1);
          state_d  = S_IDLE;
          rv_d     = 1'b1;
          res_d.status      = sha_pkg::ST_COMPACTED;
          res_d.result_base = 32'(ld_start);
          res_d.hole_count  = 5'd1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_HOLES; i++) begin
      cell_op[i] = sha_pkg::CELL_HOLD;
      if (sd_en && CW'(i) >= sd_idx) begin
        cell_op[i] = sha_pkg::CELL_FROM_NEXT;
      end else if (su_en && CW'(i) > su_idx) begin
        cell_op[i] = sha_pkg::CELL_FROM_PREV;
      end else if (ld_en && CW'(i) == ld_idx) begin
        unique case (ld_kind)
          LD_START: cell_op[i] = sha_pkg::CELL_LD_START;
          LD_END:   cell_op[i] = sha_pkg::CELL_LD_END;
          default:  cell_op[i] = sha_pkg::CELL_LD_BOTH;
        endcase
      end
    end
  end

  for (genvar g = 0; g < MAX_HOLES; g++) begin : g_cell
    logic [AW-1:0] p_start, p_end, n_start, n_end;
    if (g == 0) begin : g_first
      assign p_start = '0;
      assign p_end   = '0;
    end else begin : g_prev
      assign p_start = cell_start[g-1];
      assign p_end   = cell_end[g-1];
    end
    if (g == MAX_HOLES - 1) begin : g_last
      assign n_start = '0;
      assign n_end   = '0;
    end else begin : g_next
      assign n_start = cell_start[g+1];
      assign n_end   = cell_end[g+1];
    end
    sha_cell #(.AW(AW)) u_cell (
      .clk_i       (clk_i),
      .op_i        (cell_op[g]),
      .ld_start_i  (ld_start),
      .ld_end_i    (ld_end),
      .prev_start_i(p_start),
      .prev_end_i  (p_end),
      .next_start_i(n_start),
      .next_end_i  (n_end),
      .start_o     (cell_start[g]),
      .end_o       (cell_end[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
      fit_q   <= 2'd0;
      mem_q   <= AW'(32'd4096);
      rsv_q   <= AW'(32'd128);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          sha_pkg::CFG_FIT_MODE:      fit_q <= cfg_data_i[1:0];
          sha_pkg::CFG_MEMORY_SIZE:   mem_q <= AW'(cfg_data_i);
          sha_pkg::CFG_RESERVED_SIZE: rsv_q <= AW'(cfg_data_i);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    found_q  <= found_d;
    pick_q   <= pick_d;
    up_q     <= up_d;
    psize_q  <= psize_d;
    pstart_q <= pstart_d;
    pend_q   <= pend_d;
    sum_q    <= sum_d;
    rq_q     <= rq_d;
    rb_q     <= rb_d;
    rl_q     <= rl_d;
    res_q    <= res_d;
  end

  assign res_valid_o = rv_q;
  assign res_o       = res_q;

endmodule

FILE: hw/rtl/sha_chk.sv
// Port-level checker for the segment hole allocator, bound to the top level.
// Depends on sha_pkg.
module sha_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              res_valid_o,
  input sha_pkg::sha_res_t res_o
);

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || res_valid_o) else $error("accepted beat made no progress");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o) else $error("command ended without result");

  a_no_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy) else $error("result while still busy");

  a_single_hole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.status == sha_pkg::ST_INITIALIZED ||
                    res_o.status == sha_pkg::ST_COMPACTED) |-> res_o.hole_count == 5'd1)
    else $error("init or compact left more than one hole");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.status <= sha_pkg::ST_INITIALIZED) else $error("bad status");

endmodule

bind segment_hole_allocator sha_chk u_sha_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);

FILE: verif/sha_checker.sv
`timescale 1ns / 1ps
// Checker for the segment hole allocator: keeps its own hole table, predicts each result.
// Watches the command, result and register channels; depends on sha_pkg.
module sha_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  sha_pkg::sha_req_t req_i,
  input  logic              res_valid_o,
  input  sha_pkg::sha_res_t res_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [31:0]       cfg_data_i,
  output int                fail_count,
  output int                pending_count,
  output int                result_count
);
  import sha_pkg::*;

  localparam int NHOLES = 16;

  logic [31:0] lo_q [NHOLES];
  logic [31:0] hi_q [NHOLES];
  int          nvalid;
  logic [1:0]  fit_q;
  logic [31:0] msize_q;
  logic [31:0] rsize_q;
  sha_res_t    results_due [$];

  function automatic logic [31:0] span(int i);
    return (hi_q[i] > lo_q[i]) ? hi_q[i] - lo_q[i] : 32'd0;
  endfunction

  function automatic logic [31:0] free_sum();
    logic [32:0] acc;
    acc = 33'd0;
    for (int i = 0; i < nvalid; i++) begin
      acc = acc + span(i);
      if (acc[32]) acc = {1'b0, 32'hFFFF_FFFF};
    end
    return acc[31:0];
  endfunction

  function automatic void drop_hole(int i);
    for (int k = i; k < nvalid - 1; k++) begin
      lo_q[k] = lo_q[k+1];
      hi_q[k] = hi_q[k+1];
    end
    nvalid--;
  endfunction

  function automatic void add_hole(int i, logic [31:0] s, logic [31:0] e);
    if (nvalid >= NHOLES) return;
    for (int k = nvalid; k > i; k--) begin
      lo_q[k] = lo_q[k-1];
      hi_q[k] = hi_q[k-1];
    end
    lo_q[i] = s;
    hi_q[i] = e;
    nvalid++;
  endfunction

  function automatic sha_res_t predict_result(sha_req_t r);
    sha_res_t    o;
    bit          hit;
    int          pick;
    int          up;
    int          pos;
    logic [31:0] f;
    o = '0;
    case (r.cmd)
      CMD_INIT: begin
        nvalid = 0;
        add_hole(0, rsize_q, msize_q);
        o.result_base = rsize_q;
        o.status = ST_INITIALIZED;
      end
      CMD_ALLOCATE: begin
        hit = 0;
        pick = 0;
        for (int i = 0; i < nvalid; i++) begin
          if (r.request_size > span(i)) continue;
          if (!hit) begin
            hit = 1;
            pick = i;
            if (fit_q != FIT_BEST && fit_q != FIT_WORST) break;
          end else if (fit_q == FIT_BEST && span(i) < span(pick)) begin
            pick = i;
          end else if (fit_q == FIT_WORST && span(i) > span(pick)) begin
            pick = i;
          end
        end
        if (!hit) begin
          o.status = (free_sum() >= r.request_size) ? ST_COMPACT_REQ : ST_NO_MEMORY;
        end else begin
          o.status = ST_ALLOCATED;
          o.result_base = lo_q[pick];
          f = lo_q[pick] + r.request_size;
          if (f == hi_q[pick]) drop_hole(pick);
          else lo_q[pick] = f;
        end
      end
      CMD_FREE: begin
        hit = 0;
        up = 0;
        for (int i = 0; i < nvalid; i++) begin
          if (r.region_limit < lo_q[i]) break;
          if (r.region_limit == lo_q[i]) begin
            if (hit) begin
              hi_q[up] = hi_q[i];
              drop_hole(i);
            end else begin
              lo_q[i] = r.region_base;
              hit = 1;
            end
            break;
          end
          if (r.region_base == hi_q[i]) begin
            up = i;
            hi_q[i] = r.region_limit;
            hit = 1;
          end
        end
        o.status = ST_FREED;
        if (!hit) begin
          if (nvalid >= NHOLES) begin
            o.status = ST_TABLE_FULL;
          end else begin
            pos = 0;
            while (pos < nvalid && !(r.region_base < lo_q[pos])) pos++;
            add_hole(pos, r.region_base, r.region_limit);
          end
        end
      end
      default: begin
        f = free_sum();
        o.result_base = (f >= msize_q) ? 32'd0 : msize_q - f;
        nvalid = 0;
        add_hole(0, o.result_base, msize_q);
        o.status = ST_COMPACTED;
      end
    endcase
    o.hole_count = nvalid[4:0];
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sha_res_t want;
    if (!rst_ni) begin
      nvalid = 0;
      fit_q = 2'd0;
      msize_q = 32'd4096;
      rsize_q = 32'd128;
      fail_count <= 0;
      result_count <= 0;
      results_due.delete();
    end else begin
      if (res_valid_o) begin
        result_count <= result_count + 1;
        if (results_due.size() == 0) begin
          $display("%0t: unexpected beat, actual %p", $time, res_o);
          fail_count <= fail_count + 1;
        end else begin
          want = results_due.pop_front();
          if (want.status != res_o.status || want.result_base != res_o.result_base ||
              want.hole_count != res_o.hole_count) begin
            $display("%0t: mismatch, expected %p actual %p", $time, want, res_o);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) results_due.push_back(predict_result(req_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FIT_MODE:      fit_q = cfg_data_i[1:0];
          CFG_MEMORY_SIZE:   msize_q = cfg_data_i;
          CFG_RESERVED_SIZE: rsize_q = cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign pending_count = results_due.size();
endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for segment_hole_allocator: drives commands and register writes.
// Depends on sha_pkg, the block and sha_checker, which predicts and compares.
module tb_top;
  import sha_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  sha_req_t    req_i;
  logic        res_valid_o;
  sha_res_t    res_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  int          fail_count;
  int          pending_count;
  int          result_count;
  int          gap_left;
  logic [31:0] mem_now;

  segment_hole_allocator i_dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  sha_checker i_checker (
    .clk_i, .rst_ni, .start, .busy, .req_i, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i, .fail_count, .pending_count, .result_count
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("segment_hole_allocator regression: fail");
    $finish;
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending_count != 0 || busy) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic issue(logic [1:0] cmd, logic [31:0] sz, logic [31:0] b, logic [31:0] l,
                       bit may_idle);
    @(posedge clk_i);
    if (may_idle && gap_left == 0 && $urandom_range(0, 3) == 0)
      gap_left = $urandom_range(1, 12);
    while (gap_left > 0) begin
      @(posedge clk_i);
      gap_left--;
    end
    start <= 1'b1;
    req_i <= '{cmd: cmd, request_size: sz, region_base: b, region_limit: l};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    start <= 1'b0;
  endtask

  function automatic logic [31:0] any_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  task automatic random_phase(int n, bit may_idle);
    logic [31:0] b;
    logic [31:0] sz;
    int          k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      sz = $urandom_range(1, mem_now > 600 ? 600 : 8);
      b = $urandom_range(0, mem_now > 4 ? mem_now - 1 : 4);
      if (k < 3) issue(CMD_INIT, $urandom, $urandom, $urandom, may_idle);
      else if (k < 45) issue(CMD_ALLOCATE, sz, $urandom, $urandom, may_idle);
      else if (k < 85) issue(CMD_FREE, $urandom, b, b + sz, may_idle);
      else if (k < 90) issue(CMD_COMPACT, $urandom, $urandom, $urandom, may_idle);
      else issue(2'($urandom), any_word(), any_word(), any_word(), may_idle);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_FIT_MODE;
    cfg_data_i = '0;
    gap_left = 0;
    mem_now = 32'd4096;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, extremes, fill table to full, merges
    issue(CMD_ALLOCATE, 32'd0, 32'd0, 32'd0, 0);
    issue(CMD_ALLOCATE, 32'hFFFF_FFFF, 32'd0, 32'd0, 0);
    issue(CMD_COMPACT, 32'd0, 32'd0, 32'd0, 0);
    issue(CMD_INIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    issue(CMD_ALLOCATE, 32'd100, 32'd0, 32'd0, 0);
    issue(CMD_ALLOCATE, 32'hFFFF_FFFF, 32'd0, 32'd0, 0);
    for (int i = 0; i < 16; i++)
      issue(CMD_FREE, 32'd0, 32'd10 * i, 32'd10 * i + 5, 0);
    issue(CMD_FREE, 32'd0, 32'd5, 32'd10, 0);
    issue(CMD_FREE, 32'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 0);
    issue(CMD_FREE, 32'd0, 32'd30, 32'd20, 0);
    issue(CMD_ALLOCATE, 32'd5000, 32'd0, 32'd0, 0);
    issue(CMD_COMPACT, 32'd0, 32'd0, 32'd0, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_FIT_MODE, 2'(ph));
      case (ph)
        4: mem_now = 32'hFFFF_FFFF;
        5: mem_now = 32'd1;
        default: mem_now = $urandom_range(256, 65536);
      endcase
      write_reg(CFG_MEMORY_SIZE, mem_now);
      write_reg(CFG_RESERVED_SIZE, ph == 4 ? 32'hFFFF_FFFF :
                ph == 5 ? 32'd0 : 32'($urandom_range(0, 64)));
      issue(CMD_INIT, 32'd0, 32'd0, 32'd0, 0);
      random_phase(120, ph < 7);
      drain();
    end

    $display("covered %0d results over 8 register settings: fits, extremes, full table",
             result_count);
    if (fail_count == 0) begin
      $display("segment_hole_allocator regression: pass");
    end else begin
      $display("segment_hole_allocator regression: fail");
    end
    $finish;
  end
endmodule
